// File: rtl/core/tmp_pkg.sv
package tmp_pkg;

   localparam int CORES_DEF    = 16;
   localparam int MAX_RESULTS  = 8;
   localparam int UTIL_W       = 16;
   localparam int TEMP_W       = 16;
   localparam int COOL_W       = 40;
   localparam int TIME_W       = 48;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 40;
   localparam int REQ_DATA_W   = 88;
   localparam int RSP_DATA_W   = 16;
   localparam logic [15:0] TEMP_THR_RESET = 16'd1280;

   localparam logic [CSR_IDX_W-1:0] CSR_UTIL_THR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_THR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLDOWN = 2'd2;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_PLAN = 1'b1;

   // one table entry as stored in the sample memory
   typedef struct packed {
      logic [UTIL_W-1:0] util;
      logic [TEMP_W-1:0] temp;
      logic              temp_ok;
      logic              active;
      logic              reserved;
   } entry_type;

   typedef struct packed {
      logic       has_move;
      logic [3:0] from_core;
      logic [3:0] to_core;
      logic       swap_flag;
      logic       last;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COUNT,     // sweep: count active, find first active, coolest target
      ST_SGL_DEC,   // single core decision
      ST_RANK_A,    // read entry c
      ST_RANK_B,    // sweep d against c
      ST_PAIR_A,    // read rank tables for pair
      ST_PAIR_B,    // read high entry
      ST_PAIR_C,    // capture high entry, read low entry
      ST_EMIT,      // decide pair; hold pending result until taken
      ST_FLUSH      // final result / empty marker
   } state_type;

endpackage

// File: rtl/core/tmp_mem.sv
module tmp_mem
   import tmp_pkg::*;
#(
   parameter int CORES = CORES_DEF,
   localparam int IW = (CORES > 1) ? $clog2(CORES) : 1
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [IW-1:0]   wr_addr,
   input  entry_type       wr_data,
   input  logic [IW-1:0]   rd_addr,
   output entry_type       rd_data
);

   entry_type mem [CORES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/tmp_rank.sv
module tmp_rank
   import tmp_pkg::*;
#(
   parameter int CORES = CORES_DEF,
   localparam int IW = (CORES > 1) ? $clog2(CORES) : 1
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [IW-1:0]   wr_addr,
   input  logic [IW-1:0]   wr_data,
   input  logic [IW-1:0]   rd_addr,
   output logic [IW-1:0]   rd_data
);

   // rank table: position -> core
   logic [IW-1:0] mem [CORES];
   logic [IW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/thread_migration_planner_top.sv
// Load beat: accepted, written to the sample memory if its index is below CORES, no response.
// Plan beat: one sweep over the sample memory, then for two or more active cores a rank
// pass (one memory read per cycle), then a pair pass through PAIR_A, PAIR_B, PAIR_C and
// EMIT for each pair; each result waits in the output register.
// One plan at a time; req_tready is low while a plan runs or a result is pending.
// Synchronous reset (active high) restores control state, thresholds and move record.
module thread_migration_planner_top
   import tmp_pkg::*;
#(
   parameter int CORES = CORES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // action, core_index[3:0], utilization[15:0], temperature[15:0], temp_ok,
   // core_active, core_reserved, now_ns[47:0]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // has_move, from_core[3:0], to_core[3:0], swap_flag, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IW = (CORES > 1) ? $clog2(CORES) : 1;
   localparam int CW = $clog2(CORES + 1);
   localparam int HALF = CORES / 2;
   localparam int NW = $clog2(MAX_RESULTS + 1);

   // input fields
   logic              f_action;
   logic [3:0]        f_index;
   logic [TIME_W-1:0] f_now;
   entry_type         f_entry;
   assign f_action         = req_tdata[0];
   assign f_index          = req_tdata[4:1];
   assign f_entry.util     = req_tdata[20:5];
   assign f_entry.temp     = req_tdata[36:21];
   assign f_entry.temp_ok  = req_tdata[37];
   assign f_entry.active   = req_tdata[38];
   assign f_entry.reserved = req_tdata[39];
   assign f_now            = req_tdata[87:40];

   // configuration
   logic [UTIL_W-1:0] util_thr_ff;
   logic [TEMP_W-1:0] temp_thr_ff;
   logic [COOL_W-1:0] cool_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         util_thr_ff <= '0;
         temp_thr_ff <= TEMP_THR_RESET;
         cool_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_UTIL_THR: util_thr_ff <= csr_wdata[UTIL_W-1:0];
            CSR_TEMP_THR: temp_thr_ff <= csr_wdata[TEMP_W-1:0];
            CSR_COOLDOWN: cool_ff     <= csr_wdata[COOL_W-1:0];
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;
   logic [CW-1:0] ca_ff, ca_in;     // sweep counter c / pair index
   logic [CW-1:0] cb_ff, cb_in;     // inner sweep d
   logic [CW-1:0] nact_ff, nact_in;
   logic [IW-1:0] src_ff, src_in;
   logic          src_found_ff, src_found_in;
   logic [TEMP_W-1:0] src_t_ff, src_t_in;
   logic [IW-1:0] tgt_ff, tgt_in;
   logic          tgt_found_ff, tgt_found_in;
   logic [TEMP_W-1:0] best_ff, best_in;
   entry_type     ec_ff, ec_in;      // entry c during ranking / hi during pairing
   logic [CW-1:0] rd_ff, rd_in, ra_ff, ra_in;
   logic [NW-1:0] nres_ff, nres_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic          rec_ff, rec_in;
   logic [TIME_W-1:0] lmt_ff, lmt_in;
   logic [IW-1:0] hi_ff, hi_in;
   logic [IW-1:0] lo_ff, lo_in;
   result_type    pend_ff, pend_in;  // result held back until next or end
   logic          pend_v_ff, pend_v_in;
   result_type    out_ff, out_in;
   logic          out_v_ff, out_v_in;
   logic          emit_next_ff, emit_next_in; // in EMIT: 1 pair still to decide, 0 return to PAIR_A

   // memories
   logic          mem_we;
   logic [IW-1:0] mem_wa, mem_ra;
   entry_type     mem_rd;
   tmp_mem #(.CORES(CORES)) u_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(f_entry),
      .rd_addr(mem_ra), .rd_data(mem_rd));

   logic          hl_we, lh_we;
   logic [IW-1:0] hl_wa, lh_wa, rk_wd, hl_ra, lh_ra, hl_rd, lh_rd;
   tmp_rank #(.CORES(CORES)) u_hl (
      .clock(clock), .wr_en(hl_we), .wr_addr(hl_wa), .wr_data(rk_wd),
      .rd_addr(hl_ra), .rd_data(hl_rd));
   tmp_rank #(.CORES(CORES)) u_lh (
      .clock(clock), .wr_en(lh_we), .wr_addr(lh_wa), .wr_data(rk_wd),
      .rd_addr(lh_ra), .rd_data(lh_rd));

   wire req_fire = req_tvalid && req_tready;
   wire rsp_fire = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {6'd0, out_ff.swap_flag, out_ff.to_core, out_ff.from_core,
                        out_ff.has_move};
   assign rsp_tlast  = out_ff.last;

   // wide compares for cooldown
   logic [TIME_W-1:0] elapsed;
   logic              in_cool;
   assign elapsed = now_ff - lmt_ff;
   assign in_cool = rec_ff && (now_ff >= lmt_ff) && (elapsed < {8'd0, cool_ff});

   logic [TEMP_W:0] tdelta;
   assign tdelta = {1'b0, src_t_ff} - {1'b0, best_ff};

   logic [UTIL_W:0] ugap;

   always_comb begin
      state_in = state_ff; ca_in = ca_ff; cb_in = cb_ff; nact_in = nact_ff;
      src_in = src_ff; src_found_in = src_found_ff; src_t_in = src_t_ff;
      tgt_in = tgt_ff; tgt_found_in = tgt_found_ff; best_in = best_ff;
      ec_in = ec_ff; rd_in = rd_ff; ra_in = ra_ff; nres_in = nres_ff;
      now_in = now_ff; rec_in = rec_ff; lmt_in = lmt_ff; hi_in = hi_ff; lo_in = lo_ff;
      pend_in = pend_ff; pend_v_in = pend_v_ff; out_in = out_ff; out_v_in = out_v_ff;
      emit_next_in = emit_next_ff;
      mem_we = 1'b0; mem_wa = IW'(f_index); mem_ra = '0;
      hl_we = 1'b0; lh_we = 1'b0; hl_wa = rd_ff[IW-1:0]; lh_wa = ra_ff[IW-1:0];
      rk_wd = ca_ff[IW-1:0]; hl_ra = ca_ff[IW-1:0]; lh_ra = ca_ff[IW-1:0];
      ugap = '0;
      if (rsp_fire) out_v_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (f_action == ACT_LOAD) begin
                  mem_we = ({{(32-4){1'b0}}, f_index} < 32'(CORES));
               end else begin
                  now_in = f_now;
                  ca_in = '0; nact_in = '0; src_found_in = 1'b0; src_in = '0;
                  tgt_found_in = 1'b0; tgt_in = '0; best_in = '0; src_t_in = '0;
                  state_in = ST_COUNT;
               end
            end
         end
         ST_COUNT: begin
            // ca_ff = address issued; data of ca_ff-1 valid when ca_ff>0
            mem_ra = ca_ff[IW-1:0];
            if (ca_ff != '0) begin
               if (mem_rd.active) begin
                  if (nact_ff < CW'(2)) nact_in = nact_ff + 1'b1;
                  if (!src_found_ff) begin
                     src_found_in = 1'b1;
                     src_in = IW'(ca_ff - 1'b1);
                     src_t_in = mem_rd.temp_ok ? mem_rd.temp : '0;
                  end
               end else if (mem_rd.reserved && mem_rd.temp_ok) begin
                  if (!tgt_found_ff || mem_rd.temp < best_ff) begin
                     tgt_found_in = 1'b1;
                     tgt_in = IW'(ca_ff - 1'b1);
                     best_in = mem_rd.temp;
                  end
               end
            end
            if (ca_ff == CW'(CORES)) begin
               state_in = ST_SGL_DEC;
            end else begin
               ca_in = ca_ff + 1'b1;
            end
         end
         ST_SGL_DEC: begin
            pend_v_in = 1'b0;
            nres_in = '0;
            if (nact_ff == '0) begin
               state_in = ST_FLUSH;
            end else if (nact_ff == CW'(1)) begin
               // target excludes the source since source is active
               if (!in_cool && tgt_found_ff &&
                   !tdelta[TEMP_W] && tdelta[TEMP_W-1:0] >= temp_thr_ff) begin
                  pend_in = '{has_move: 1'b1, from_core: 4'(src_ff), to_core: 4'(tgt_ff),
                              swap_flag: 1'b1, last: 1'b1};
                  pend_v_in = 1'b1;
                  rec_in = 1'b1;
                  lmt_in = now_ff;
               end
               state_in = ST_FLUSH;
            end else begin
               ca_in = '0;
               state_in = ST_RANK_A;
            end
         end
         ST_RANK_A: begin
            mem_ra = ca_ff[IW-1:0];
            cb_in = '0; rd_in = '0; ra_in = '0;
            state_in = ST_RANK_B;
         end
         ST_RANK_B: begin
            mem_ra = cb_ff[IW-1:0];
            if (cb_ff == '0) begin
               ec_in = mem_rd; // entry c arrives
            end else begin
               if (mem_rd.util > ec_ff.util ||
                   (mem_rd.util == ec_ff.util && (cb_ff - 1'b1) < ca_ff))
                  rd_in = rd_ff + 1'b1;
               if (mem_rd.util < ec_ff.util ||
                   (mem_rd.util == ec_ff.util && (cb_ff - 1'b1) < ca_ff))
                  ra_in = ra_ff + 1'b1;
            end
            if (cb_ff == CW'(CORES)) begin
               hl_we = 1'b1; lh_we = 1'b1;
               hl_wa = rd_in[IW-1:0]; lh_wa = ra_in[IW-1:0];
               if (ca_ff == CW'(CORES - 1)) begin
                  ca_in = '0;
                  state_in = ST_PAIR_A;
               end else begin
                  ca_in = ca_ff + 1'b1;
                  state_in = ST_RANK_A;
               end
            end else begin
               cb_in = cb_ff + 1'b1;
            end
         end
         ST_PAIR_A: begin
            if (ca_ff == CW'(HALF) || nres_ff == NW'(MAX_RESULTS)) begin
               state_in = ST_FLUSH;
            end else begin
               hl_ra = ca_ff[IW-1:0]; lh_ra = ca_ff[IW-1:0];
               state_in = ST_PAIR_B;
            end
         end
         ST_PAIR_B: begin
            hi_in = hl_rd; lo_in = lh_rd;
            mem_ra = hl_rd;
            state_in = ST_PAIR_C;
         end
         ST_PAIR_C: begin
            // hi data arrives; request lo
            mem_ra = lo_ff;
            ec_in = mem_rd;
            cb_in = '0;
            state_in = ST_EMIT;
            emit_next_in = 1'b1;
         end
         ST_EMIT: begin
            if (emit_next_ff) begin
               // lo data valid now
               ugap = {1'b0, ec_ff.util} - {1'b0, mem_rd.util};
               emit_next_in = 1'b0;
               ca_in = ca_ff + 1'b1;
               if (hi_ff != lo_ff && ec_ff.active && !ugap[UTIL_W] &&
                   ugap[UTIL_W-1:0] >= util_thr_ff) begin
                  if (pend_v_ff) begin
                     if (!out_v_ff || rsp_fire) begin
                        out_in = pend_ff; out_v_in = 1'b1;
                     end else begin
                        emit_next_in = 1'b1;
                        ca_in = ca_ff;
                        mem_ra = lo_ff;
                     end
                  end
                  if (!pend_v_ff || !out_v_ff || rsp_fire) begin
                     pend_in = '{has_move: 1'b1, from_core: 4'(hi_ff), to_core: 4'(lo_ff),
                                 swap_flag: mem_rd.active || mem_rd.reserved, last: 1'b0};
                     pend_v_in = 1'b1;
                     nres_in = nres_ff + 1'b1;
                  end
               end
               if (emit_next_in == 1'b0) state_in = ST_PAIR_A;
               else mem_ra = lo_ff;
            end else begin
               state_in = ST_PAIR_A;
            end
         end
         ST_FLUSH: begin
            if (!out_v_ff || rsp_fire) begin
               out_v_in = 1'b1;
               if (pend_v_ff) begin
                  out_in = pend_ff; out_in.last = 1'b1;
               end else begin
                  out_in = '{has_move: 1'b0, from_core: 4'd0, to_core: 4'd0,
                             swap_flag: 1'b0, last: 1'b1};
               end
               pend_v_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         pend_v_ff <= 1'b0;
         rec_ff <= 1'b0;
         lmt_ff <= '0;
         emit_next_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         pend_v_ff <= pend_v_in;
         rec_ff <= rec_in;
         lmt_ff <= lmt_in;
         emit_next_ff <= emit_next_in;
      end
   end

   always_ff @(posedge clock) begin
      ca_ff <= ca_in; cb_ff <= cb_in; nact_ff <= nact_in;
      src_ff <= src_in; src_found_ff <= src_found_in; src_t_ff <= src_t_in;
      tgt_ff <= tgt_in; tgt_found_ff <= tgt_found_in; best_ff <= best_in;
      ec_ff <= ec_in; rd_ff <= rd_in; ra_ff <= ra_in; nres_ff <= nres_in;
      now_ff <= now_in; hi_ff <= hi_in; lo_ff <= lo_in;
      pend_ff <= pend_in; out_ff <= out_in;
   end

endmodule

// File: rtl/core/tmp_checker.sv
module tmp_checker
   import tmp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_no_take_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while response pending");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tlast && rsp_tdata[9:1] == 9'd0)
      else $error("empty marker malformed");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind thread_migration_planner_top tmp_checker u_tmp_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast));

// File: tb/sv/tb_thread_migration_planner_top.sv
`timescale 1ns / 100ps

class migration_scoreboard;
   // sample table copy, written only by loads
   logic [15:0] util_tab [16];
   logic [15:0] temp_tab [16];
   bit          tok_tab [16];
   bit          act_tab [16];
   bit          rsv_tab [16];
   bit          moved;
   logic [47:0] last_move_ns;
   logic [15:0] util_thr;
   logic [15:0] temp_thr;
   logic [39:0] cooldown;
   tmp_pkg::result_type pending_moves[$];
   int          mismatches;

   function new();
      moved = 0;
      last_move_ns = '0;
      util_thr = '0;
      temp_thr = tmp_pkg::TEMP_THR_RESET;
      cooldown = '0;
      mismatches = 0;
      foreach (util_tab[i]) begin
         util_tab[i] = '0; temp_tab[i] = '0;
         tok_tab[i] = 0; act_tab[i] = 0; rsv_tab[i] = 0;
      end
   endfunction

   function void write_reg(logic [1:0] idx, logic [39:0] val);
      if (idx == tmp_pkg::CSR_UTIL_THR) util_thr = val[15:0];
      else if (idx == tmp_pkg::CSR_TEMP_THR) temp_thr = val[15:0];
      else if (idx == tmp_pkg::CSR_COOLDOWN) cooldown = val;
   endfunction

   function void push_move(int from, int to, bit swp);
      tmp_pkg::result_type r;
      r.has_move = 1; r.from_core = from[3:0]; r.to_core = to[3:0];
      r.swap_flag = swp; r.last = 0;
      pending_moves = {pending_moves, r};
   endfunction

   function int plan_single(logic [47:0] now);
      int src, tgt;
      logic [15:0] best;
      longint src_t;
      src = 0; tgt = -1; best = '0;
      for (int c = 15; c >= 0; c--) if (act_tab[c]) src = c;
      if (moved && now >= last_move_ns && (now - last_move_ns) < {8'd0, cooldown})
         return 0;
      src_t = tok_tab[src] ? longint'(temp_tab[src]) : 0;
      for (int c = 0; c < 16; c++) begin
         if (c == src || act_tab[c] || !rsv_tab[c] || !tok_tab[c]) continue;
         if (tgt < 0 || temp_tab[c] < best) begin
            tgt = c; best = temp_tab[c];
         end
      end
      if (tgt < 0) return 0;
      if (src_t - longint'(best) >= longint'(temp_thr)) begin
         push_move(src, tgt, 1);
         moved = 1;
         last_move_ns = now;
         return 1;
      end
      return 0;
   endfunction

   function int plan_balance();
      int by_desc [16];
      int by_asc [16];
      int n, rd, ra, hi, lo;
      n = 0;
      for (int c = 0; c < 16; c++) begin
         rd = 0; ra = 0;
         for (int d = 0; d < 16; d++) begin
            if (util_tab[d] > util_tab[c] || (util_tab[d] == util_tab[c] && d < c)) rd++;
            if (util_tab[d] < util_tab[c] || (util_tab[d] == util_tab[c] && d < c)) ra++;
         end
         by_desc[rd] = c;
         by_asc[ra] = c;
      end
      for (int i = 0; i < 8; i++) begin
         hi = by_desc[i]; lo = by_asc[i];
         if (hi == lo || !act_tab[hi]) continue;
         if (util_tab[hi] < util_tab[lo] ||
             (util_tab[hi] - util_tab[lo]) < util_thr) continue;
         if (n >= tmp_pkg::MAX_RESULTS) break;
         push_move(hi, lo, act_tab[lo] || rsv_tab[lo]);
         n++;
      end
      return n;
   endfunction

   function void note_request(logic [tmp_pkg::REQ_DATA_W-1:0] d);
      int n_act, n;
      tmp_pkg::result_type r;
      if (d[0] == tmp_pkg::ACT_LOAD) begin
         util_tab[d[4:1]] = d[20:5];
         temp_tab[d[4:1]] = d[36:21];
         tok_tab[d[4:1]] = d[37];
         act_tab[d[4:1]] = d[38];
         rsv_tab[d[4:1]] = d[39];
         return;
      end
      n_act = 0;
      foreach (act_tab[c]) if (act_tab[c]) n_act++;
      if (n_act == 0) n = 0;
      else if (n_act == 1) n = plan_single(d[87:40]);
      else n = plan_balance();
      if (n == 0) begin
         r = '0; r.last = 1;
         pending_moves = {pending_moves, r};
      end else
         pending_moves[$].last = 1;
   endfunction

   function void check_result(logic [15:0] data, logic lst);
      tmp_pkg::result_type want, got;
      got.has_move = data[0]; got.from_core = data[4:1]; got.to_core = data[8:5];
      got.swap_flag = data[9]; got.last = lst;
      if (pending_moves.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %p", got);
         return;
      end
      want = pending_moves.pop_front();
      if (got !== want || data[15:10] !== '0) begin
         mismatches++;
         if (mismatches <= 10) $display("result mismatch: expected %p got %p", want, got);
      end
   endfunction
endclass

module tb_thread_migration_planner_top;
   import tmp_pkg::*;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en = 0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   migration_scoreboard plan_sb;
   int  send_idle_pct;
   int  recv_idle_pct;
   longint cycle_count;
   logic [47:0] clock_ns;

   always #2 clock = ~clock;

   thread_migration_planner_top DUT (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("tb_thread_migration_planner_top: done, errors");
         $finish;
      end
   end

   // receiver with random stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) plan_sb.check_result(rsp_tdata, rsp_tlast);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // drop valid while idle; the last beat keeps valid until the next idle or wait
   task automatic send_beat(logic [REQ_DATA_W-1:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      plan_sb.note_request(d);
   endtask

   task automatic load_core(int idx, logic [15:0] u, logic [15:0] t,
                            bit ok, bit act, bit rsv);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[0] = ACT_LOAD; d[4:1] = idx[3:0]; d[20:5] = u; d[36:21] = t;
      d[37] = ok; d[38] = act; d[39] = rsv;
      d[87:40] = 48'({$urandom, $urandom});   // don't-care on loads, exercise bits
      send_beat(d);
   endtask

   task automatic plan(logic [47:0] now);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[0] = ACT_PLAN;
      d[39:1] = 39'({$urandom, $urandom});    // ignored on plans
      d[87:40] = now;
      send_beat(d);
   endtask

   task automatic drain_then_write(logic [1:0] idx, logic [39:0] val);
      req_tvalid <= 0;
      while (plan_sb.pending_moves.size() != 0) @(posedge clock);
      repeat (CORES_DEF * (CORES_DEF + 2) + 64) @(posedge clock);
      csr_wr_en <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      plan_sb.write_reg(idx, val);
   endtask

   task automatic load_random(int idx);
      load_core(idx, 16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   // one active core, rest idle mix, so the single-core move path is reached
   task automatic single_scene();
      int src;
      src = $urandom_range(15);
      for (int c = 0; c < 16; c++)
         load_core(c, 16'($urandom), $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom),
                   $urandom_range(3) != 0, c == src, 1'($urandom_range(1)));
   endtask

   task automatic run_random(int count);
      int k;
      k = 0;
      while (k < count) begin
         case ($urandom_range(9))
            0: begin single_scene(); k += 16; end
            1, 2, 3, 4: begin load_random($urandom_range(15)); k++; end
            default: begin
               clock_ns += $urandom_range(3) == 0 ? 48'd0 - $urandom_range(5000)
                                                 : $urandom_range(20000);
               plan(clock_ns); k++;
            end
         endcase
      end
   endtask

   initial begin
      plan_sb = new();
      cycle_count = 0;
      send_idle_pct = 21;
      recv_idle_pct = 60;
      clock_ns = 48'd1000;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: fill every core so no unwritten entry is read
      for (int c = 0; c < 16; c++) load_core(c, 16'h0, 16'h0, 0, 0, 0);
      plan(48'd0);                                   // no active core
      load_core(3, 16'hFFFF, 16'hFFFF, 1, 1, 0);     // one active core, no target
      plan(48'hFFFF_FFFF_FFFF);
      load_core(7, 16'h0, 16'h0100, 1, 0, 1);        // cool reserved target
      load_core(9, 16'h0, 16'h0100, 1, 0, 1);        // tie, lower index wins
      load_core(5, 16'h0, 16'h0000, 0, 0, 1);        // invalid reading never chosen
      plan(48'd100);
      load_core(3, 16'h8000, 16'hFFFF, 0, 1, 0);     // invalid source counts as zero
      plan(48'd200);
      load_core(12, 16'hFFFF, 16'h0, 1, 1, 1);       // two active: balance
      plan(48'd300);
      drain_then_write(CSR_COOLDOWN, 40'hFF_FFFF_FFFF);
      drain_then_write(CSR_TEMP_THR, 40'h0);
      drain_then_write(CSR_UTIL_THR, 40'hFFFF);
      plan(48'd400);
      for (int c = 0; c < 16; c++) load_core(c, c[0] ? 16'hFFFF : 16'h0, 16'h0,
                                               1, 1, c[1]);
      plan(48'd500);

      drain_then_write(CSR_UTIL_THR, 40'h0);
      drain_then_write(CSR_COOLDOWN, 40'd0);
      run_random(110);
      send_idle_pct = 60; recv_idle_pct = 21;
      drain_then_write(CSR_UTIL_THR, 40'($urandom_range(16'h4000)));
      drain_then_write(CSR_TEMP_THR, 40'd1280);
      drain_then_write(CSR_COOLDOWN, 40'd5000);
      run_random(110);
      send_idle_pct = 0; recv_idle_pct = 0;
      drain_then_write(CSR_UTIL_THR, 40'hFFFF);
      drain_then_write(CSR_TEMP_THR, 40'hFFFF);
      drain_then_write(CSR_COOLDOWN, 40'hFF_FFFF_FFFF);
      run_random(55);
      drain_then_write(CSR_UTIL_THR, 40'h0);
      drain_then_write(CSR_TEMP_THR, 40'h0);
      drain_then_write(CSR_COOLDOWN, 40'd0);
      run_random(60);

      req_tvalid <= 0;
      while (plan_sb.pending_moves.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (plan_sb.mismatches == 0)
         $display("tb_thread_migration_planner_top: done, clean");
      else
         $display("tb_thread_migration_planner_top: done, errors");
      $finish;
   end
endmodule

// File: sim.f
rtl/core/tmp_pkg.sv
rtl/core/tmp_mem.sv
rtl/core/tmp_rank.sv
rtl/core/thread_migration_planner_top.sv
rtl/core/tmp_checker.sv
tb/sv/tb_thread_migration_planner_top.sv
